@@ design/mcbt_pkg.sv @@
// ----------------------------------------------------------------------------
// mcbt_pkg
// Shared types and constants for the multi-channel blink timer.
// ----------------------------------------------------------------------------
package mcbt_pkg;

    // Command codes carried in the op field
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Edge counter preset on a start command, so the first tick toggles unless the low time is 8'hFF
    localparam logic [7:0] PRESET_COUNT = 8'hFE;
    // Blink counts above this run endless
    localparam logic [7:0] ENDLESS_LIMIT = 8'd100;

    // One command item
    typedef struct packed {
        logic       op;
        logic [2:0] channel;
        logic [7:0] blink_count;
        logic [7:0] high_time;
        logic [7:0] low_time;
    } cmd_t;

    // Stored state of one channel
    typedef struct packed {
        logic       out_level;
        logic [7:0] edge_counter;
        logic [7:0] edges_left;
        logic       endless;
        logic [7:0] on_dwell;
        logic [7:0] off_dwell;
    } chan_state_t;

    // One result item
    typedef struct packed {
        logic [2:0] out_channel;
        logic       level;
        logic       drive_written;
        logic       finished;
    } result_t;

endpackage

@@ design/mcbt_if.sv @@
// ----------------------------------------------------------------------------
// mcbt_cmd_if / mcbt_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface mcbt_cmd_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [2:0] channel;
    logic [7:0] blink_count;
    logic [7:0] high_time;
    logic [7:0] low_time;

    modport source (output valid, op, channel, blink_count, high_time, low_time,
                    input ready);
    modport sink   (input valid, op, channel, blink_count, high_time, low_time,
                    output ready);
endinterface

interface mcbt_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_channel;
    logic       level;
    logic       drive_written;
    logic       finished;

    modport source (output valid, out_channel, level, drive_written, finished,
                    input ready);
    modport sink   (input valid, out_channel, level, drive_written, finished,
                    output ready);
endinterface

@@ design/mcbt_chan_update.sv @@
// ----------------------------------------------------------------------------
// mcbt_chan_update
// Next state and result for one channel under one command item.
// ----------------------------------------------------------------------------
module mcbt_chan_update (
    input  mcbt_pkg::cmd_t       item,
    input  logic                 in_range,
    input  mcbt_pkg::chan_state_t cur,
    output mcbt_pkg::chan_state_t nxt,
    output logic                 wr_en,
    output mcbt_pkg::result_t    result
);

    logic       active;
    logic       is_endless;
    logic [7:0] dwell;
    logic [7:0] cnt_inc;
    logic [7:0] left_dec;
    logic       drove;
    logic       done;

    assign active     = cur.endless || (cur.edges_left != 8'd0);
    assign is_endless = item.blink_count > mcbt_pkg::ENDLESS_LIMIT;
    assign dwell      = cur.out_level ? cur.on_dwell : cur.off_dwell;
    assign cnt_inc    = cur.edge_counter + 8'd1;
    assign left_dec   = cur.edges_left - 8'd1;

    // Apply start or tick to the channel state
    always_comb
    begin
        nxt   = cur;
        wr_en = 1'b0;
        drove = 1'b0;
        done  = 1'b0;
        if (in_range)
        begin
            if (item.op == mcbt_pkg::OP_START)
            begin
                wr_en            = 1'b1;
                drove            = 1'b1;
                nxt.out_level    = 1'b0;
                nxt.edge_counter = mcbt_pkg::PRESET_COUNT;
                nxt.endless      = is_endless;
                nxt.edges_left   = is_endless ? 8'd0 : {item.blink_count[6:0], 1'b0};
                nxt.on_dwell     = item.high_time;
                nxt.off_dwell    = item.low_time;
            end
            else if (active)
            begin
                wr_en            = 1'b1;
                nxt.edge_counter = cnt_inc;
                // Toggle once the dwell for the current level has passed
                if (cnt_inc > dwell)
                begin
                    drove            = 1'b1;
                    nxt.edge_counter = 8'd1;
                    nxt.out_level    = ~cur.out_level;
                    if (!cur.endless)
                    begin
                        nxt.edges_left = left_dec;
                        done           = (left_dec == 8'd0);
                    end
                end
            end
        end
    end

    // Build the result item
    always_comb
    begin
        result.out_channel   = item.channel;
        result.level         = in_range ? nxt.out_level : 1'b0;
        result.drive_written = drove;
        result.finished      = done;
    end

endmodule

@@ design/multi_channel_blink_timer.sv @@
// ----------------------------------------------------------------------------
// multi_channel_blink_timer
// Bank of blinking outputs driven by start and tick command items.
// ----------------------------------------------------------------------------
// Takes one command item per clock while results are taken and returns
// exactly one result item per command. An accepted item waits in an input
// register; once the result register has room, the addressed channel's state
// is read, updated by one pass of combinational logic, written back and the
// result registered. Back-to-back items on the same channel see each other's
// updates, so while results are taken the sustained rate is one item per
// cycle, limited only by the single read-modify-write of channel state.
// Commands for channels at or above CHANNELS change nothing and report low.
module multi_channel_blink_timer #(
    parameter int CHANNELS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    mcbt_cmd_if.sink      cmd,
    mcbt_res_if.source    res
);

    // The channel field reaches at most eight entries
    localparam int DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mcbt_pkg::cmd_t        cmd_reg;
    logic                  cmd_valid_reg;
    mcbt_pkg::result_t     res_reg;
    mcbt_pkg::result_t     res_next;
    logic                  res_valid_reg;
    mcbt_pkg::chan_state_t state_reg [DEPTH];
    mcbt_pkg::chan_state_t state_next;
    mcbt_pkg::chan_state_t cur;
    logic                  wr_en;
    logic                  in_range;
    logic                  adv;
    logic [IDX_W-1:0]      idx;

    // Move the held item into the result register when there is room
    assign adv       = cmd_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !cmd_valid_reg || adv;

    assign in_range = int'(cmd_reg.channel) < CHANNELS;
    assign idx      = IDX_W'(cmd_reg.channel);
    assign cur      = state_reg[idx];

    mcbt_chan_update u_update (
        .item     (cmd_reg),
        .in_range (in_range),
        .cur      (cur),
        .nxt      (state_next),
        .wr_en    (wr_en),
        .result   (res_next)
    );

    // Track occupancy of the input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.op          <= cmd.op;
            cmd_reg.channel     <= cmd.channel;
            cmd_reg.blink_count <= cmd.blink_count;
            cmd_reg.high_time   <= cmd.high_time;
            cmd_reg.low_time    <= cmd.low_time;
        end
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    // Write back the addressed channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (adv && wr_en)
        begin
            state_reg[idx] <= state_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.out_channel   = res_reg.out_channel;
    assign res.level         = res_reg.level;
    assign res.drive_written = res_reg.drive_written;
    assign res.finished      = res_reg.finished;

    // A completed sequence always ends on a toggle back to low
    a_finish_low: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.finished |-> res.drive_written && !res.level)
        else $error("finished without a toggle to low");

    // The input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> res_valid_reg && !res.ready)
        else $error("input stalled without a pending result");

    // Every processed item appears as a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> res.valid)
        else $error("processed item produced no result");

endmodule

@@ tb/multi_channel_blink_timer_tb.sv @@
// ----------------------------------------------------------------------------
// multi_channel_blink_timer_tb
// Self-checking bench for the blink timer bank. A directed sequence covers
// inactive ticks, zero and endless blink counts, dwell extremes and counter
// wrap. A long random stream of start and tick items follows. Each accepted
// command is run through a behavioral model of all channels. Each result is
// checked field by field against the oldest predicted result. Both the
// command and the result side idle and stall at random.
// ----------------------------------------------------------------------------
module multi_channel_blink_timer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHANNELS = 8;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk = 1'b0;
    logic rst_n;

    mcbt_cmd_if cmd ();
    mcbt_res_if res ();

    multi_channel_blink_timer #(.CHANNELS(NUM_CHANNELS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    always #6 clk = ~clk;

    // Channel state of the behavioral model
    logic       lvl_q       [NUM_CHANNELS];
    logic [7:0] tick_cnt_q  [NUM_CHANNELS];
    logic [7:0] toggles_q   [NUM_CHANNELS];
    logic       endless_q   [NUM_CHANNELS];
    logic [7:0] on_time_q   [NUM_CHANNELS];
    logic [7:0] off_time_q  [NUM_CHANNELS];

    mcbt_pkg::cmd_t    pending_cmds [$];
    mcbt_pkg::result_t expected_results [$];
    int                error_count = 0;
    int                cycle_count = 0;

    // Apply one command to the channel model and return the result it causes
    function automatic mcbt_pkg::result_t blink_step(mcbt_pkg::cmd_t c);
        mcbt_pkg::result_t r;
        logic [7:0]        dwell;
        int                ch;
        ch              = int'(c.channel);
        r.out_channel   = c.channel;
        r.level         = 1'b0;
        r.drive_written = 1'b0;
        r.finished      = 1'b0;
        if (ch < NUM_CHANNELS) begin
            if (c.op == mcbt_pkg::OP_START) begin
                lvl_q[ch]      = 1'b0;
                tick_cnt_q[ch] = mcbt_pkg::PRESET_COUNT;
                if (c.blink_count > mcbt_pkg::ENDLESS_LIMIT) begin
                    endless_q[ch] = 1'b1;
                    toggles_q[ch] = 8'd0;
                end
                else begin
                    endless_q[ch] = 1'b0;
                    toggles_q[ch] = {c.blink_count[6:0], 1'b0};
                end
                on_time_q[ch]   = c.high_time;
                off_time_q[ch]  = c.low_time;
                r.drive_written = 1'b1;
            end
            else if (endless_q[ch] || toggles_q[ch] != 8'd0) begin
                dwell          = lvl_q[ch] ? on_time_q[ch] : off_time_q[ch];
                tick_cnt_q[ch] = tick_cnt_q[ch] + 8'd1;
                if (tick_cnt_q[ch] > dwell) begin
                    tick_cnt_q[ch]  = 8'd1;
                    lvl_q[ch]       = ~lvl_q[ch];
                    r.drive_written = 1'b1;
                    if (!endless_q[ch]) begin
                        toggles_q[ch] = toggles_q[ch] - 8'd1;
                        if (toggles_q[ch] == 8'd0)
                            r.finished = 1'b1;
                    end
                end
            end
            r.level = lvl_q[ch];
        end
        return r;
    endfunction

    function automatic mcbt_pkg::cmd_t make_cmd(logic op, logic [2:0] ch,
                                                logic [7:0] cnt, logic [7:0] hi,
                                                logic [7:0] lo);
        mcbt_pkg::cmd_t c;
        c.op          = op;
        c.channel     = ch;
        c.blink_count = cnt;
        c.high_time   = hi;
        c.low_time    = lo;
        return c;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_dwell();
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(1, 4));
        if (r < 50)
            return 8'd0;
        if (r < 55)
            return mcbt_pkg::ENDLESS_LIMIT;
        if (r < 60)
            return mcbt_pkg::ENDLESS_LIMIT + 8'd1;
        if (r < 65)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Command driver: pop pending items, insert random gaps, predict on accept
    int gap_left;
    int send_burst;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd.valid       <= 1'b0;
            cmd.op          <= mcbt_pkg::OP_TICK;
            cmd.channel     <= '0;
            cmd.blink_count <= '0;
            cmd.high_time   <= '0;
            cmd.low_time    <= '0;
            gap_left        <= 0;
            send_burst      <= 0;
        end
        else begin
            if (cmd.valid && cmd.ready)
                expected_results.push_back(blink_step(make_cmd(cmd.op, cmd.channel,
                    cmd.blink_count, cmd.high_time, cmd.low_time)));
            if (!cmd.valid || cmd.ready) begin
                if (gap_left > 0) begin
                    gap_left  <= gap_left - 1;
                    cmd.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0) begin
                    mcbt_pkg::cmd_t c;
                    c = pending_cmds.pop_front();
                    cmd.valid       <= 1'b1;
                    cmd.op          <= c.op;
                    cmd.channel     <= c.channel;
                    cmd.blink_count <= c.blink_count;
                    cmd.high_time   <= c.high_time;
                    cmd.low_time    <= c.low_time;
                    if (send_burst > 0) begin
                        send_burst <= send_burst - 1;
                        gap_left   <= 0;
                    end
                    else begin
                        gap_left <= idle_len();
                        if ($urandom_range(0, 49) == 0)
                            send_burst <= $urandom_range(20, 60);
                    end
                end
                else begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stalls, compare against the oldest prediction
    int stall_left;
    int take_burst;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res.ready  <= 1'b0;
            stall_left <= 0;
            take_burst <= 0;
        end
        else begin
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result ch=%0d lvl=%0b drv=%0b fin=%0b",
                             $time, res.out_channel, res.level, res.drive_written,
                             res.finished);
                end
                else begin
                    mcbt_pkg::result_t e;
                    e = expected_results.pop_front();
                    if (res.out_channel !== e.out_channel) begin
                        error_count++;
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $time, e.out_channel, res.out_channel);
                    end
                    if (res.level !== e.level) begin
                        error_count++;
                        $display("%0t: ch %0d level expected %0b actual %0b",
                                 $time, e.out_channel, e.level, res.level);
                    end
                    if (res.drive_written !== e.drive_written) begin
                        error_count++;
                        $display("%0t: ch %0d drive_written expected %0b actual %0b",
                                 $time, e.out_channel, e.drive_written, res.drive_written);
                    end
                    if (res.finished !== e.finished) begin
                        error_count++;
                        $display("%0t: ch %0d finished expected %0b actual %0b",
                                 $time, e.out_channel, e.finished, res.finished);
                    end
                end
            end
            // hold off the result side now and then
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                res.ready  <= 1'b0;
            end
            else begin
                res.ready <= 1'b1;
                if (take_burst > 0)
                    take_burst <= take_burst - 1;
                else if ($urandom_range(0, 49) == 0)
                    take_burst <= $urandom_range(20, 60);
                else if ($urandom_range(0, 2) == 0)
                    stall_left <= idle_len();
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus and end of test
    initial begin
        mcbt_pkg::cmd_t c;
        rst_n           = 1'b0;
        cmd.valid       = 1'b0;
        cmd.op          = mcbt_pkg::OP_TICK;
        cmd.channel     = '0;
        cmd.blink_count = '0;
        cmd.high_time   = '0;
        cmd.low_time    = '0;
        res.ready       = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            lvl_q[i]      = 1'b0;
            tick_cnt_q[i] = 8'd0;
            toggles_q[i]  = 8'd0;
            endless_q[i]  = 1'b0;
            on_time_q[i]  = 8'd0;
            off_time_q[i] = 8'd0;
        end

        // tick on a channel left idle by reset
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd0, 8'hFF, 8'hFF, 8'hFF));
        // zero blink count leaves the channel inactive
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_START, 3'd1, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd1, 8'd0, 8'd0, 8'd0));
        // single blink with zero dwell: toggle on, toggle off and finish, then idle
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_START, 3'd2, 8'd1, 8'd0, 8'd0));
        repeat (3)
            pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd2, 8'd0, 8'd0, 8'd0));
        // endless mode just above the limit
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_START, 3'd3,
                                        mcbt_pkg::ENDLESS_LIMIT + 8'd1, 8'd1, 8'd2));
        repeat (4)
            pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd3, 8'd0, 8'd0, 8'd0));
        // count at the limit with maximum dwell: counter wraps, no toggle
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_START, 3'd4,
                                        mcbt_pkg::ENDLESS_LIMIT, 8'hFF, 8'hFF));
        repeat (3)
            pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd4, 8'd0, 8'd0, 8'd0));
        // endless with the largest count, alternating dwell bits
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_START, 3'd5, 8'hFF, 8'hAA, 8'h55));
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd5, 8'd0, 8'd0, 8'd0));
        // two blinks on the top channel, interleaved with another channel
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_START, 3'd7, 8'd2, 8'd0, 8'd1));
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd7, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd3, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd7, 8'd0, 8'd0, 8'd0));
        // restart an active channel mid-sequence
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_START, 3'd3, 8'd1, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(mcbt_pkg::OP_TICK, 3'd3, 8'd0, 8'd0, 8'd0));

        // random stream: starts with random content, mostly ticks
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            c.channel = 3'($urandom_range(0, NUM_CHANNELS - 1));
            if ($urandom_range(0, 99) < 15) begin
                c.op          = mcbt_pkg::OP_START;
                c.blink_count = pick_count();
                c.high_time   = pick_dwell();
                c.low_time    = pick_dwell();
            end
            else begin
                c.op          = mcbt_pkg::OP_TICK;
                c.blink_count = 8'($urandom_range(0, 255));
                c.high_time   = 8'($urandom_range(0, 255));
                c.low_time    = 8'($urandom_range(0, 255));
            end
            pending_cmds.push_back(c);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // drain stimulus, then outstanding results
        while (pending_cmds.size() > 0 || cmd.valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
